FILE: rtl/core/rpn_pkg.sv
// package for the rpn stack calculator: payload types, codes and state encoding
package rpn_pkg;

  typedef enum logic [3:0] {
    CMD_PUSH   = 4'd0,
    CMD_ADD    = 4'd1,
    CMD_SUB    = 4'd2,
    CMD_MUL    = 4'd3,
    CMD_DIV    = 4'd4,
    CMD_NEG    = 4'd5,
    CMD_DUP    = 4'd6,
    CMD_SWAP   = 4'd7,
    CMD_PRINT  = 4'd8,
    CMD_CLEAR  = 4'd9,
    CMD_LIST   = 4'd10
  } cmd_e;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_SHOWN   = 3'd1,
    ST_FEW     = 3'd2,
    ST_DIVZERO = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef struct packed {
    logic [3:0]         cmd;
    logic signed [31:0] operand;
  } in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
    logic               last;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_TOP,
    S_RD_SEC,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_WB1,
    S_WB2,
    S_LIST_RD,
    S_LIST_OUT,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    RD_TOP,
    RD_SEC,
    RD_LIST
  } rd_sel_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_PUSH,
    WR_DUP,
    WR_RES,
    WR_SWAP_HI,
    WR_SWAP_LO,
    WR_NEG
  } wr_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_e;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } alu_op_e;

  typedef struct packed {
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    cap_top;
    logic    cap_sec;
    wr_sel_e wr_sel;
    cnt_op_e cnt_op;
    logic    alu_start;
    alu_op_e alu_op;
    logic    res_cap;
    logic    list_init;
    logic    list_step;
    logic    out_load;
    logic    out_show;
    logic    out_last;
    status_e out_status;
  } ctrl_t;

  typedef struct packed {
    logic empty;
    logic one_only;
    logic full;
    logic top_zero;
    logic alu_busy;
    logic list_last;
    logic out_busy;
  } stat_t;

endpackage

FILE: rtl/core/rpn_alu.sv
// fixed-point multiply and iterative divide unit with saturation
module rpn_alu import rpn_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  alu_op_e            op_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic               busy_o,
  output logic signed [31:0] res_o
);

  localparam int NumW  = 32 + FRACTION_BITS;
  localparam int CntW  = $clog2(NumW + 2);
  localparam logic signed [63:0] Max32 = 64'sd2147483647;
  localparam logic signed [63:0] Min32 = -64'sd2147483648;

  logic              busy_q, busy_d;
  logic              is_div_q, is_div_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [NumW-1:0]   num_q, num_d;
  logic [32:0]       rem_q, rem_d;
  logic [31:0]       den_q, den_d;
  logic              neg_q, neg_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [31:0] res_q, res_d;

  logic [31:0] a_abs, b_abs;
  logic [32:0] rem_sh, rem_sub;
  logic signed [63:0] mq, dq;
  logic [63:0] qmag;

  always_comb begin
    a_abs   = a_i[31] ? 32'(-a_i) : 32'(a_i);
    b_abs   = b_i[31] ? 32'(-b_i) : 32'(b_i);
    rem_sh  = {rem_q[31:0], num_q[NumW-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    mq      = prod_q >>> FRACTION_BITS;
    qmag    = 64'(num_q);
    dq      = neg_q ? -$signed(qmag) : $signed(qmag);
  end

  always_comb begin
    busy_d   = busy_q;
    is_div_d = is_div_q;
    cnt_d    = cnt_q;
    num_d    = num_q;
    rem_d    = rem_q;
    den_d    = den_q;
    neg_d    = neg_q;
    prod_d   = prod_q;
    res_d    = res_q;
    if (start_i) begin
      busy_d   = 1'b1;
      is_div_d = (op_i == OP_DIV);
      num_d    = NumW'(a_abs) << FRACTION_BITS;
      rem_d    = '0;
      den_d    = b_abs;
      neg_d    = a_i[31] ^ b_i[31];
      prod_d   = a_i * b_i;
      cnt_d    = (op_i == OP_DIV) ? CntW'(NumW) : CntW'(1);
    end else if (busy_q) begin
      if (is_div_q) begin
        if (cnt_q != '0) begin
          if (!rem_sub[32]) begin
            rem_d = rem_sub;
            num_d = {num_q[NumW-2:0], 1'b1};
          end else begin
            rem_d = rem_sh;
            num_d = {num_q[NumW-2:0], 1'b0};
          end
          cnt_d = cnt_q - CntW'(1);
        end else begin
          busy_d = 1'b0;
          if (dq > Max32) res_d = 32'sh7fffffff;
          else if (dq < Min32) res_d = 32'sh80000000;
          else res_d = 32'(dq);
        end
      end else begin
        busy_d = 1'b0;
        if (mq > Max32) res_d = 32'sh7fffffff;
        else if (mq < Min32) res_d = 32'sh80000000;
        else res_d = 32'(mq);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_div_q <= is_div_d;
    cnt_q    <= cnt_d;
    num_q    <= num_d;
    rem_q    <= rem_d;
    den_q    <= den_d;
    neg_q    <= neg_d;
    prod_q   <= prod_d;
    res_q    <= res_d;
  end

  assign busy_o = busy_q;
  assign res_o  = res_q;

endmodule

FILE: rtl/core/rpn_datapath.sv
// datapath: stack memory, count, operand registers, alu and output register
module rpn_datapath import rpn_pkg::*; #(
  parameter int STACK_DEPTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  in_t                in_i,
  input  logic               in_cap_i,
  input  ctrl_t              ctrl_i,
  output stat_t              stat_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_o
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic signed [31:0] mem [STACK_DEPTH];
  logic signed [31:0] rd_q;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic signed [31:0] opnd_q, top_q, sec_q, res_q;
  logic               out_valid_q;
  out_t               out_q;

  logic [CW-1:0]      rd_addr_w, wr_addr_w;
  logic               wr_en;
  logic signed [31:0] wr_data, addsub, negv;
  logic signed [32:0] sum33;
  logic               alu_busy;
  logic signed [31:0] alu_res;

  rpn_alu #(.FRACTION_BITS(FRACTION_BITS)) u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl_i.alu_start),
    .op_i    (ctrl_i.alu_op),
    .a_i     (sec_q),
    .b_i     (top_q),
    .busy_o  (alu_busy),
    .res_o   (alu_res)
  );

  always_comb begin
    unique case (ctrl_i.rd_sel)
      RD_TOP:  rd_addr_w = cnt_q - CW'(1);
      RD_SEC:  rd_addr_w = cnt_q - CW'(2);
      default: rd_addr_w = idx_q - CW'(1);
    endcase
  end

  always_comb begin
    sum33 = (ctrl_i.alu_op == OP_SUB) ? 33'(sec_q) - 33'(top_q) : 33'(sec_q) + 33'(top_q);
    if (sum33[32] != sum33[31]) addsub = sum33[32] ? 32'sh80000000 : 32'sh7fffffff;
    else addsub = sum33[31:0];
    negv = (top_q == 32'sh80000000) ? 32'sh7fffffff : -top_q;
  end

  always_comb begin
    wr_en     = 1'b1;
    wr_addr_w = cnt_q;
    wr_data   = opnd_q;
    unique case (ctrl_i.wr_sel)
      WR_PUSH:    begin wr_addr_w = cnt_q;          wr_data = opnd_q; end
      WR_DUP:     begin wr_addr_w = cnt_q;          wr_data = top_q;  end
      WR_RES:     begin wr_addr_w = cnt_q - CW'(2); wr_data = res_q;  end
      WR_SWAP_HI: begin wr_addr_w = cnt_q - CW'(1); wr_data = sec_q;  end
      WR_SWAP_LO: begin wr_addr_w = cnt_q - CW'(2); wr_data = top_q;  end
      WR_NEG:     begin wr_addr_w = cnt_q - CW'(1); wr_data = negv;   end
      default:    wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr_w[AW-1:0]] <= wr_data;
    if (ctrl_i.rd_en) rd_q <= mem[rd_addr_w[AW-1:0]];
  end

  always_comb begin
    unique case (ctrl_i.cnt_op)
      CNT_INC: cnt_d = cnt_q + CW'(1);
      CNT_DEC: cnt_d = cnt_q - CW'(1);
      CNT_CLR: cnt_d = '0;
      default: cnt_d = cnt_q;
    endcase
    idx_d = idx_q;
    if (ctrl_i.list_init) idx_d = cnt_q;
    else if (ctrl_i.list_step) idx_d = idx_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (ctrl_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (in_cap_i) opnd_q <= in_i.operand;
    if (ctrl_i.cap_top) top_q <= rd_q;
    if (ctrl_i.cap_sec) sec_q <= rd_q;
    if (ctrl_i.res_cap) res_q <= (ctrl_i.alu_op == OP_ADD || ctrl_i.alu_op == OP_SUB)
                                 ? addsub : alu_res;
    if (ctrl_i.out_load) begin
      out_q.value  <= ctrl_i.out_show ? rd_q : 32'sd0;
      out_q.status <= ctrl_i.out_status;
      out_q.last   <= ctrl_i.out_last;
    end
  end

  assign stat_o.empty     = (cnt_q == '0);
  assign stat_o.one_only  = (cnt_q == CW'(1));
  assign stat_o.full      = (cnt_q >= CW'(STACK_DEPTH));
  assign stat_o.top_zero  = (top_q == 32'sd0);
  assign stat_o.alu_busy  = alu_busy;
  assign stat_o.list_last = (idx_q == CW'(1));
  assign stat_o.out_busy  = out_valid_q && !out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_o            = out_q;

endmodule

FILE: rtl/core/rpn_ctrl.sv
// controller state machine sequencing each command
module rpn_ctrl import rpn_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  in_t   in_i,
  output logic  in_ready_o,
  output ctrl_t ctrl_o,
  input  stat_t stat_i
);

  state_e  state_q, state_d;
  logic [3:0] cmd_q, cmd_d;
  status_e st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= CMD_PUSH;
      st_q    <= ST_DONE;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      st_q    <= st_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    st_d    = st_q;
    ctrl_o  = '0;
    ctrl_o.rd_sel = RD_TOP;
    ctrl_o.wr_sel = WR_NONE;
    ctrl_o.cnt_op = CNT_HOLD;
    ctrl_o.out_status = ST_DONE;
    unique case (cmd_q)
      CMD_SUB: ctrl_o.alu_op = OP_SUB;
      CMD_MUL: ctrl_o.alu_op = OP_MUL;
      CMD_DIV: ctrl_o.alu_op = OP_DIV;
      default: ctrl_o.alu_op = OP_ADD;
    endcase
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = in_i.cmd;
          st_d    = ST_DONE;
          state_d = S_OUT;
          unique case (in_i.cmd) inside
            CMD_PUSH: begin
              if (stat_i.full) st_d = ST_FULL;
              else state_d = S_WB1;
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_SWAP: begin
              if (stat_i.empty || stat_i.one_only) st_d = ST_FEW;
              else state_d = S_RD_TOP;
            end
            CMD_NEG, CMD_PRINT: begin
              if (stat_i.empty) st_d = ST_FEW;
              else state_d = S_RD_TOP;
            end
            CMD_DUP: begin
              if (stat_i.empty) st_d = ST_FEW;
              else if (stat_i.full) st_d = ST_FULL;
              else state_d = S_RD_TOP;
            end
            CMD_CLEAR: ctrl_o.cnt_op = CNT_CLR;
            CMD_LIST: begin
              if (!stat_i.empty) begin
                ctrl_o.list_init = 1'b1;
                state_d = S_LIST_RD;
              end
            end
            default: ;
          endcase
          if (in_i.cmd == CMD_PRINT && !stat_i.empty) ctrl_o.rd_en = 1'b1;
          if (state_d == S_RD_TOP) ctrl_o.rd_en = 1'b1;
        end
      end
      S_RD_TOP: begin
        ctrl_o.cap_top = 1'b1;
        if (cmd_q == CMD_PRINT) begin
          if (!stat_i.out_busy) begin
            ctrl_o.out_load   = 1'b1;
            ctrl_o.out_show   = 1'b1;
            ctrl_o.out_last   = 1'b1;
            ctrl_o.out_status = ST_SHOWN;
            state_d = S_IDLE;
          end
        end else if (cmd_q == CMD_NEG || cmd_q == CMD_DUP) begin
          state_d = S_EXEC;
        end else begin
          ctrl_o.rd_en  = 1'b1;
          ctrl_o.rd_sel = RD_SEC;
          state_d = S_RD_SEC;
        end
      end
      S_RD_SEC: begin
        ctrl_o.cap_sec = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_OUT;
        unique case (cmd_q)
          CMD_NEG:  ctrl_o.wr_sel = WR_NEG;
          CMD_DUP: begin
            ctrl_o.wr_sel = WR_DUP;
            ctrl_o.cnt_op = CNT_INC;
          end
          CMD_SWAP: begin
            ctrl_o.wr_sel = WR_SWAP_HI;
            state_d = S_WB2;
          end
          CMD_MUL, CMD_DIV: begin
            if (cmd_q == CMD_DIV && stat_i.top_zero) st_d = ST_DIVZERO;
            else begin
              ctrl_o.alu_start = 1'b1;
              state_d = S_MUL;
            end
          end
          default: begin
            ctrl_o.res_cap = 1'b1;
            state_d = S_DIV;
          end
        endcase
      end
      S_MUL: begin
        if (!stat_i.alu_busy) begin
          ctrl_o.res_cap = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        ctrl_o.wr_sel = WR_RES;
        ctrl_o.cnt_op = CNT_DEC;
        state_d = S_OUT;
      end
      S_WB1: begin
        ctrl_o.wr_sel = WR_PUSH;
        ctrl_o.cnt_op = CNT_INC;
        state_d = S_OUT;
      end
      S_WB2: begin
        ctrl_o.wr_sel = WR_SWAP_LO;
        state_d = S_OUT;
      end
      S_LIST_RD: begin
        ctrl_o.rd_en  = 1'b1;
        ctrl_o.rd_sel = RD_LIST;
        state_d = S_LIST_OUT;
      end
      S_LIST_OUT: begin
        if (!stat_i.out_busy) begin
          ctrl_o.out_load   = 1'b1;
          ctrl_o.out_show   = 1'b1;
          ctrl_o.out_status = ST_SHOWN;
          ctrl_o.out_last   = stat_i.list_last;
          ctrl_o.list_step  = 1'b1;
          state_d = stat_i.list_last ? S_IDLE : S_LIST_RD;
        end
      end
      S_OUT: begin
        if (!stat_i.out_busy) begin
          ctrl_o.out_load   = 1'b1;
          ctrl_o.out_last   = 1'b1;
          ctrl_o.out_status = st_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/rpn_stack_calculator.sv
// top level of the rpn stack calculator
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_ready_o | in_i (cmd, operand)
//   out     | output    | out_valid_o/out_ready_i | out_o (value, status, last)
// divide uses a restoring divider that forms one quotient bit per cycle;
// list reads the stack entries one at a time through the single memory read
// port. reset empties the stack at once.
// a result waiting in the output register holds the controller, so the
// next command waits too.
module rpn_stack_calculator import rpn_pkg::*; #(
  parameter int STACK_DEPTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  ctrl_t ctrl;
  stat_t stat;
  logic  in_cap;

  assign in_cap = in_valid_i && in_ready_o;

  rpn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_i       (in_i),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl),
    .stat_i     (stat)
  );

  rpn_datapath #(
    .STACK_DEPTH   (STACK_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .in_cap_i    (in_cap),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

FILE: sim/rpn_result_checker.sv
// checker for the rpn stack calculator: watches both channels and predicts every result
`timescale 1ns / 1ps
module rpn_result_checker import rpn_pkg::*; #(
  parameter int STACK_DEPTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   result_count_o
);

  logic signed [31:0] calc_stack [STACK_DEPTH];
  int unsigned        calc_depth;
  out_t               result_queue [$];

  function automatic logic signed [31:0] clamp32(logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic out_t mk_result(logic signed [31:0] v, status_e s, logic l);
    out_t r;
    r.value  = v;
    r.status = s;
    r.last   = l;
    return r;
  endfunction

  task automatic predict_command(in_t cmd_in);
    logic signed [31:0] top, second, res;
    logic signed [65:0] wide;
    status_e            st;
    int unsigned        n;
    n = calc_depth;
    st = ST_DONE;
    top = (n >= 1) ? calc_stack[n-1] : 32'sd0;
    second = (n >= 2) ? calc_stack[n-2] : 32'sd0;
    case (cmd_in.cmd)
      CMD_PUSH: begin
        if (n >= STACK_DEPTH) st = ST_FULL;
        else begin
          calc_stack[n] = cmd_in.operand;
          calc_depth = n + 1;
        end
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
        if (n < 2) st = ST_FEW;
        else if (cmd_in.cmd == CMD_DIV && top == 0) st = ST_DIVZERO;
        else begin
          case (cmd_in.cmd)
            CMD_ADD: wide = 66'(second) + 66'(top);
            CMD_SUB: wide = 66'(second) - 66'(top);
            CMD_MUL: wide = (66'(second) * 66'(top)) >>> FRACTION_BITS;
            default: wide = (66'(second) <<< FRACTION_BITS) / 66'(top);
          endcase
          res = clamp32(wide);
          calc_stack[n-2] = res;
          calc_depth = n - 1;
        end
      end
      CMD_NEG: begin
        if (n < 1) st = ST_FEW;
        else calc_stack[n-1] = clamp32(-66'(top));
      end
      CMD_DUP: begin
        if (n < 1) st = ST_FEW;
        else if (n >= STACK_DEPTH) st = ST_FULL;
        else begin
          calc_stack[n] = top;
          calc_depth = n + 1;
        end
      end
      CMD_SWAP: begin
        if (n < 2) st = ST_FEW;
        else begin
          calc_stack[n-1] = second;
          calc_stack[n-2] = top;
        end
      end
      CMD_PRINT: begin
        if (n < 1) st = ST_FEW;
        else begin
          result_queue.push_back(mk_result(top, ST_SHOWN, 1'b1));
          return;
        end
      end
      CMD_CLEAR: calc_depth = 0;
      CMD_LIST: begin
        if (n > 0) begin
          for (int i = 0; i < n; i++)
            result_queue.push_back(mk_result(calc_stack[n-1-i], ST_SHOWN, i + 1 == n));
          return;
        end
      end
      default: ;
    endcase
    result_queue.push_back(mk_result(32'sd0, st, 1'b1));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      calc_depth <= 0;
      fail_count_o <= 0;
      result_count_o <= 0;
      result_queue.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        result_count_o <= result_count_o + 1;
        if (result_queue.size() == 0) begin
          $display("%0t: unexpected result value=%h status=%0d last=%b", $time,
                   out_i.value, out_i.status, out_i.last);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = result_queue.pop_front();
          if (out_i !== want) begin
            $display("%0t: mismatch expected value=%h status=%0d last=%b actual value=%h status=%0d last=%b",
                     $time, want.value, want.status, want.last,
                     out_i.value, out_i.status, out_i.last);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_command(in_i);
    end
  end

  assign pending_o = result_queue.size();

endmodule

FILE: sim/tb_rpn_stack_calculator.sv
// testbench top for the rpn stack calculator: stimulus, idling phases and verdict
`timescale 1ns / 1ps
module tb_rpn_stack_calculator;
  import rpn_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_o;
  int   fail_count, pending, result_count;
  int   send_idle_pct = 0, recv_stall_pct = 0;
  int   sent_count = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  rpn_stack_calculator i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_i,
    .out_valid_o, .out_ready_i, .out_o
  );

  rpn_result_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_i(out_o),
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count)
  );

  always @(posedge clk_i)
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($urandom_range(7)) << 16;
      3: return $urandom_range(3) - 1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_command(cmd_e c, logic [31:0] opnd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_i.cmd <= c;
    in_i.operand <= opnd;
    in_valid_i <= 1'b1;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    sent_count++;
  endtask

  task automatic send_raw(logic [3:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_i.cmd <= c;
    in_i.operand <= $urandom;
    in_valid_i <= 1'b1;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    sent_count++;
  endtask

  task automatic random_command();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) send_command(CMD_PUSH, rand_operand());
    else if (pick < 96) send_command(cmd_e'($urandom_range(1, 10)), $urandom);
    else send_raw(4'($urandom_range(11, 15)));
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: errors on empty stack, extremes, saturation, divide by zero
    send_command(CMD_LIST, '0);
    send_command(CMD_ADD, '0);
    send_command(CMD_NEG, '0);
    send_command(CMD_DUP, '0);
    send_command(CMD_PRINT, '0);
    send_command(CMD_PUSH, 32'h80000000);
    send_command(CMD_SWAP, '0);
    send_command(CMD_NEG, '0);
    send_command(CMD_PUSH, 32'h7fffffff);
    send_command(CMD_ADD, '0);
    send_command(CMD_PUSH, 32'h80000000);
    send_command(CMD_SUB, '0);
    send_command(CMD_PUSH, 32'h0);
    send_command(CMD_DIV, '0);
    send_command(CMD_PUSH, 32'hffff8000);
    send_command(CMD_MUL, '0);
    send_command(CMD_PUSH, 32'h00000001);
    send_command(CMD_DIV, '0);
    send_command(CMD_PRINT, '0);
    send_command(CMD_LIST, '0);
    send_raw(4'hf);
    send_command(CMD_CLEAR, '0);
    // fill past full, then list the whole stack
    for (int i = 0; i < 33; i++) send_command(CMD_PUSH, $urandom);
    send_command(CMD_DUP, '0);
    send_command(CMD_LIST, '0);
    send_command(CMD_CLEAR, '0);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 81 : (ph == 3) ? 27 : 0;
      recv_stall_pct = (ph == 2) ? 81 : (ph == 3) ? 27 : 0;
      for (int k = 0; k < 75; k++) random_command();
    end
    in_valid_i <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("sent %0d commands covering every opcode, overflow and error paths;", sent_count);
    $display("checked %0d results under four idling mixes", result_count);
    if (fail_count == 0) $display("tb_rpn_stack_calculator: PASS");
    else $display("tb_rpn_stack_calculator: FAIL");
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_rpn_stack_calculator: FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/rpn_pkg.sv
rtl/core/rpn_alu.sv
rtl/core/rpn_datapath.sv
rtl/core/rpn_ctrl.sv
rtl/core/rpn_stack_calculator.sv
sim/rpn_result_checker.sv
sim/tb_rpn_stack_calculator.sv
